### rtl/core/multi_axis_rotary_position_rotate_assert.svh
// assertion macros for the rotary position rotate block
`ifndef MULTI_AXIS_ROTARY_POSITION_ROTATE_ASSERT_SVH
`define MULTI_AXIS_ROTARY_POSITION_ROTATE_ASSERT_SVH

// property must hold at every clock edge outside reset
`define MARPR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define MARPR_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### rtl/core/marpr_pkg.sv
// shared constants, types and tables of the rotary position rotate block
package marpr_pkg;

	localparam int VEC_DIM_DEF = 128;
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = 6;
	localparam int AXIS_LIMIT = 60;
	localparam int AXIS_COUNT = 3;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_ROTATE = 1'b1;

	localparam logic [1:0] AXIS_T = 2'd0;
	localparam logic [1:0] AXIS_H = 2'd1;
	localparam logic [1:0] AXIS_W = 2'd2;

	localparam logic [34:0] TWO_PI_Q32 = 35'h6487ED511;
	localparam logic [34:0] PI_Q32 = 35'h3243F6A89;
	localparam logic [34:0] HALF_PI_Q32 = 35'h1921FB544;
	localparam logic [34:0] QUARTER_PI_Q32 = 35'h0C90FDAA2;
	localparam logic [32:0] Q32_ONE = 33'h100000000;

	localparam int PROD_W = 48;
	localparam int MOD_CELLS = 14;
	localparam int STEP_LAT = 3;
	localparam int SIN_STEPS = 4;
	localparam int COS_STEPS = 5;
	localparam int SIN_DIV [SIN_STEPS] = '{72, 42, 20, 6};
	localparam int COS_DIV [COS_STEPS] = '{90, 56, 30, 12, 2};

	// edges from the s1 register to the s35 point where sin and cos meet
	localparam int SIDE_DEPTH = 1 + MOD_CELLS + 3 + 1 + COS_STEPS * STEP_LAT;
	localparam int FLAG_DEPTH = 1 + COS_STEPS * STEP_LAT;
	localparam int SIN_PAD = (COS_STEPS - SIN_STEPS) * STEP_LAT - 1;
	localparam int LATENCY = 1 + SIDE_DEPTH + 4;

	typedef logic [TABLE_DEPTH-1:0][1:0] axis_map_t;

	typedef struct packed {
		logic v;
		logic byp;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} side_t;

	function automatic axis_map_t build_axis_map();
		axis_map_t m;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (i < AXIS_LIMIT && i % AXIS_COUNT == 1)
				m[i] = AXIS_H;
			else if (i < AXIS_LIMIT && i % AXIS_COUNT == 2)
				m[i] = AXIS_W;
			else
				m[i] = AXIS_T;
		end
		return m;
	endfunction

	localparam axis_map_t AXIS_MAP = build_axis_map();

endpackage

### rtl/core/marpr_ram.sv
// generic single port ram with registered read
module marpr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
endmodule

### rtl/core/marpr_delay.sv
// fixed length register line
module marpr_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);
	logic [WIDTH-1:0] line_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				line_q[i] <= '0;
		end else begin
			line_q[0] <= d;
			for (int i = 1; i < DEPTH; i++)
				line_q[i] <= line_q[i-1];
		end
	end

	assign q = line_q[DEPTH-1];
endmodule

### rtl/core/marpr_mod_cell.sv
// one restoring step of the reduction modulo two pi
module marpr_mod_cell #(
	parameter int SHIFT = 0
) (
	input  logic                       clk,
	input  logic [marpr_pkg::PROD_W-1:0] rem_i,
	output logic [marpr_pkg::PROD_W-1:0] rem_o
);
	import marpr_pkg::*;

	localparam logic [PROD_W:0] STEP = (PROD_W + 1)'(TWO_PI_Q32) << SHIFT;

	logic [PROD_W-1:0] rem_q;

	always_ff @(posedge clk) begin
		if ({1'b0, rem_i} >= STEP)
			rem_q <= PROD_W'({1'b0, rem_i} - STEP);
		else
			rem_q <= rem_i;
	end

	assign rem_o = rem_q;
endmodule

### rtl/core/marpr_step_cell.sv
// one horner step of the series: s = 1 - (x2 * s) / divisor
module marpr_step_cell #(
	parameter int DIVISOR = 2
) (
	input  logic        clk,
	input  logic [31:0] x2_i,
	input  logic [32:0] s_i,
	output logic [31:0] x2_o,
	output logic [32:0] s_o
);
	import marpr_pkg::*;

	// floor(2^34 / divisor), estimate is exact or one low
	localparam logic [33:0] RECIP = 34'((35'd1 << 34) / DIVISOR);

	logic [31:0] m_s1, x2_s1;
	logic [31:0] qe_s2, m_s2, x2_s2;
	logic [32:0] s_s3;
	logic [31:0] x2_s3;
	logic [39:0] rem;
	logic [31:0] q;

	always_comb begin
		rem = 40'(m_s2) - 40'(qe_s2) * 40'(DIVISOR);
		q = qe_s2 + ((rem >= 40'(DIVISOR)) ? 32'd1 : 32'd0);
	end

	always_ff @(posedge clk) begin
		m_s1 <= 32'((65'(x2_i) * 65'(s_i)) >> 32);
		x2_s1 <= x2_i;
		qe_s2 <= 32'((66'(m_s1) * 66'(RECIP)) >> 34);
		m_s2 <= m_s1;
		x2_s2 <= x2_s1;
		s_s3 <= Q32_ONE - 33'(q);
		x2_s3 <= x2_s2;
	end

	assign s_o = s_s3;
	assign x2_o = x2_s3;
endmodule

### rtl/core/multi_axis_rotary_position_rotate.sv
// top level of the multi axis rotary position rotate block
//
// channel   direction  handshake              payload
// command   in         start & !busy          command, pair_index, freq_value, pos_*, *_value
// result    out        strobe, one cycle      first_out, second_out
//
// one transaction is taken every cycle, busy stays low
// a rotate result passes through the 14 remainder cells, the fold registers and the five series
// cells of the cosine, then the undo, product and rounding registers, before it is strobed
// a write command gives no result, its entry is readable from the next cycle on
// reset clears the side line, the delay lines and the strobe only; the table stays undefined until written
// the receiver cannot stall, each result is shown for exactly one cycle
module multi_axis_rotary_position_rotate #(
	parameter int VEC_DIM = marpr_pkg::VEC_DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          command,
	input  logic [marpr_pkg::IDX_W-1:0]   pair_index,
	input  logic [31:0]                   freq_value,
	input  logic [15:0]                   pos_temporal,
	input  logic [15:0]                   pos_height,
	input  logic [15:0]                   pos_width,
	input  logic signed [31:0]            first_value,
	input  logic signed [31:0]            second_value,
	output logic                          strobe,
	output logic signed [31:0]            first_out,
	output logic signed [31:0]            second_out
);
	import marpr_pkg::*;

	localparam int HALF_DIM = VEC_DIM / 2;

	logic accept;
	logic [15:0] coord;
	logic [31:0] freq_s1;
	logic [15:0] coord_s1;
	side_t side_s1, side_s35, side_s36, side_s37, side_s38;
	logic [PROD_W-1:0] prod_s2;
	logic [PROD_W-1:0] rem_c [MOD_CELLS+1];
	logic [34:0] red_s17, red_s18;
	logic neg_s17, neg_s18, neg_s19, swap_s18, swap_s19, comp_s19;
	logic [31:0] x_s19, x_s20, x2_s20, x_s32;
	logic [34:0] half_sub, half_clamp;
	logic [31:0] cx2 [COS_STEPS+1];
	logic [32:0] cos_c [COS_STEPS+1];
	logic [31:0] sx2 [SIN_STEPS+1];
	logic [32:0] sin_c [SIN_STEPS+1];
	logic [32:0] sin_s33, sin_s35;
	logic [2:0] flags_s35;
	logic sel, neg_s, neg_c;
	logic [32:0] smag, cmag;
	logic signed [31:0] sv, cv;
	logic signed [31:0] s30_s36, c30_s36;
	logic signed [63:0] pac_s37, pbs_s37, pas_s37, pbc_s37;
	logic signed [63:0] y1_s38, y2_s38;
	logic strobe_q;
	logic signed [31:0] first_q, second_q;

	function automatic logic signed [31:0] round_sat(input logic signed [63:0] y);
		logic signed [63:0] t;
		t = (y + 64'sd536870912) >>> 30;
		if (t > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (t < -64'sd2147483648)
			return 32'sh80000000;
		else
			return t[31:0];
	endfunction

	// every cycle can take a transaction
	assign busy = 1'b0;
	assign accept = start & ~busy;

	marpr_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (accept && command == CMD_WRITE),
		.addr  (pair_index),
		.wdata (freq_value),
		.rdata (freq_s1)
	);

	// axis rule from the constant map
	always_comb begin
		unique case (AXIS_MAP[pair_index])
			AXIS_H: coord = pos_height;
			AXIS_W: coord = pos_width;
			default: coord = pos_temporal;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else begin
			side_s1.v <= accept && command == CMD_ROTATE;
			side_s1.byp <= {1'b0, pair_index} >= (IDX_W + 1)'(HALF_DIM);
			side_s1.a <= first_value;
			side_s1.b <= second_value;
		end
	end

	always_ff @(posedge clk) begin
		coord_s1 <= coord;
		prod_s2 <= PROD_W'(coord_s1) * PROD_W'(freq_s1);
	end

	// angle reduction, one quotient bit per cell, high bit first
	assign rem_c[0] = prod_s2;
	for (genvar g = 0; g < MOD_CELLS; g++) begin : g_mod
		marpr_mod_cell #(.SHIFT(MOD_CELLS - 1 - g)) u_cell (
			.clk   (clk),
			.rem_i (rem_c[g]),
			.rem_o (rem_c[g+1])
		);
	end

	// fold into [0, pi/4] with sign and swap flags
	always_comb begin
		half_sub = (red_s17 >= HALF_PI_Q32) ? red_s17 - HALF_PI_Q32 : red_s17;
		half_clamp = (half_sub > HALF_PI_Q32) ? HALF_PI_Q32 : half_sub;
	end

	always_ff @(posedge clk) begin
		neg_s17 <= rem_c[MOD_CELLS][34:0] >= PI_Q32;
		red_s17 <= (rem_c[MOD_CELLS][34:0] >= PI_Q32) ?
			rem_c[MOD_CELLS][34:0] - PI_Q32 : rem_c[MOD_CELLS][34:0];
		neg_s18 <= neg_s17;
		swap_s18 <= red_s17 >= HALF_PI_Q32;
		red_s18 <= half_clamp;
		neg_s19 <= neg_s18;
		swap_s19 <= swap_s18;
		comp_s19 <= red_s18 > QUARTER_PI_Q32;
		x_s19 <= (red_s18 > QUARTER_PI_Q32) ? 32'(HALF_PI_Q32 - red_s18) : red_s18[31:0];
		x_s20 <= x_s19;
		x2_s20 <= 32'((64'(x_s19) * 64'(x_s19)) >> 32);
	end

	// series cells for cosine and sine
	assign cx2[0] = x2_s20;
	assign cos_c[0] = Q32_ONE;
	for (genvar g = 0; g < COS_STEPS; g++) begin : g_cos
		marpr_step_cell #(.DIVISOR(COS_DIV[g])) u_cell (
			.clk  (clk),
			.x2_i (cx2[g]),
			.s_i  (cos_c[g]),
			.x2_o (cx2[g+1]),
			.s_o  (cos_c[g+1])
		);
	end

	assign sx2[0] = x2_s20;
	assign sin_c[0] = Q32_ONE;
	for (genvar g = 0; g < SIN_STEPS; g++) begin : g_sin
		marpr_step_cell #(.DIVISOR(SIN_DIV[g])) u_cell (
			.clk  (clk),
			.x2_i (sx2[g]),
			.s_i  (sin_c[g]),
			.x2_o (sx2[g+1]),
			.s_o  (sin_c[g+1])
		);
	end

	marpr_delay #(.WIDTH(32), .DEPTH(SIN_STEPS * STEP_LAT)) u_x_dly (
		.clk (clk), .arst_n (arst_n), .d (x_s20), .q (x_s32)
	);

	always_ff @(posedge clk) begin
		sin_s33 <= 33'((65'(x_s32) * 65'(sin_c[SIN_STEPS])) >> 32);
	end

	marpr_delay #(.WIDTH(33), .DEPTH(SIN_PAD)) u_sin_dly (
		.clk (clk), .arst_n (arst_n), .d (sin_s33), .q (sin_s35)
	);

	marpr_delay #(.WIDTH(3), .DEPTH(FLAG_DEPTH)) u_flag_dly (
		.clk (clk), .arst_n (arst_n), .d ({neg_s19, swap_s19, comp_s19}), .q (flags_s35)
	);

	marpr_delay #(.WIDTH($bits(side_t)), .DEPTH(SIDE_DEPTH)) u_side_dly (
		.clk (clk), .arst_n (arst_n), .d (side_s1), .q (side_s35)
	);

	// undo the folds and round to q30
	always_comb begin
		sel = flags_s35[0] ^ flags_s35[1];
		neg_s = flags_s35[2];
		neg_c = flags_s35[2] ^ flags_s35[1];
		smag = sel ? cos_c[COS_STEPS] : sin_s35;
		cmag = sel ? sin_s35 : cos_c[COS_STEPS];
		sv = 32'((34'(smag) + 34'd2) >> 2);
		cv = 32'((34'(cmag) + 34'd2) >> 2);
	end

	always_ff @(posedge clk) begin
		s30_s36 <= neg_s ? -sv : sv;
		c30_s36 <= neg_c ? -cv : cv;
		pac_s37 <= 64'(side_s36.a) * 64'(c30_s36);
		pbs_s37 <= 64'(side_s36.b) * 64'(s30_s36);
		pas_s37 <= 64'(side_s36.a) * 64'(s30_s36);
		pbc_s37 <= 64'(side_s36.b) * 64'(c30_s36);
		y1_s38 <= pac_s37 - pbs_s37;
		y2_s38 <= pas_s37 + pbc_s37;
		// pairs past the head pass through unchanged
		first_q <= side_s38.byp ? side_s38.a : round_sat(y1_s38);
		second_q <= side_s38.byp ? side_s38.b : round_sat(y2_s38);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s36 <= '0;
			side_s37 <= '0;
			side_s38 <= '0;
			strobe_q <= 1'b0;
		end else begin
			side_s36 <= side_s35;
			side_s37 <= side_s36;
			side_s38 <= side_s37;
			strobe_q <= side_s38.v;
		end
	end

	assign strobe = strobe_q;
	assign first_out = first_q;
	assign second_out = second_q;
endmodule

### rtl/core/marpr_checker.sv
// port level checks of the rotary position rotate block and their binding
`include "multi_axis_rotary_position_rotate_assert.svh"

module marpr_checker #(
	parameter int VEC_DIM = marpr_pkg::VEC_DIM_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        command,
	input logic [marpr_pkg::IDX_W-1:0] pair_index,
	input logic signed [31:0]          first_value,
	input logic signed [31:0]          second_value,
	input logic                        strobe,
	input logic signed [31:0]          first_out,
	input logic signed [31:0]          second_out
);
	import marpr_pkg::*;

	localparam int HALF_DIM = VEC_DIM / 2;

	logic rot_acc, pass_acc;

	assign rot_acc = start && !busy && command == CMD_ROTATE;
	assign pass_acc = rot_acc && ({1'b0, pair_index} >= (IDX_W + 1)'(HALF_DIM));

	`MARPR_ASSERT_NEVER(a_never_busy, busy, "busy raised")
	`MARPR_ASSERT(a_rot_gives_result, rot_acc |-> ##LATENCY strobe, "rotate lost")
	`MARPR_ASSERT(a_result_has_cause, strobe |-> $past(rot_acc, LATENCY), "result invented")
	`MARPR_ASSERT(a_pass_through, pass_acc |-> ##LATENCY (first_out == $past(first_value, LATENCY) && second_out == $past(second_value, LATENCY)), "pass pair changed")
endmodule

bind multi_axis_rotary_position_rotate marpr_checker #(.VEC_DIM(VEC_DIM)) u_marpr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.command      (command),
	.pair_index   (pair_index),
	.first_value  (first_value),
	.second_value (second_value),
	.strobe       (strobe),
	.first_out    (first_out),
	.second_out   (second_out)
);

### tb/rotate_checker.sv
// checker for the rotary position rotate block: predicts rotated pairs and compares results
module rotate_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               command,
	input  logic [5:0]         pair_index,
	input  logic [31:0]        freq_value,
	input  logic [15:0]        pos_temporal,
	input  logic [15:0]        pos_height,
	input  logic [15:0]        pos_width,
	input  logic signed [31:0] first_value,
	input  logic signed [31:0] second_value,
	input  logic               strobe,
	input  logic signed [31:0] first_out,
	input  logic signed [31:0] second_out,
	output int                 fail_count,
	output int                 pending,
	output int                 rotates_seen
);
	import marpr_pkg::*;

	localparam longint ONE = 64'h1_0000_0000;

	logic [31:0] freq_mem [TABLE_DEPTH];
	logic [63:0] want_first [$];
	logic [63:0] want_second [$];

	initial fail_count = 0;
	initial rotates_seen = 0;
	initial pending = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] exp);
		$display("mismatch %s: got %h expected %h at %0t", what, got, exp, $time);
		fail_count++;
	endtask

	function automatic longint unsigned qmul(input longint unsigned a, input longint unsigned b);
		logic [127:0] p;
		p = a * b;
		return p[95:32];
	endfunction

	function automatic longint to_q30(input longint unsigned mag, input bit neg);
		longint v;
		v = longint'((mag + 2) >> 2);
		return neg ? -v : v;
	endfunction

	function automatic logic [31:0] round_clip(input longint v);
		longint q;
		v += longint'(1) << 29;
		q = v >>> 30;
		if (q > 64'sd2147483647) q = 64'sd2147483647;
		if (q < -64'sd2147483648) q = -64'sd2147483648;
		return q[31:0];
	endfunction

	// sine and cosine in q30 of an angle already reduced into [0, 2pi)
	task automatic angle_sin_cos(input longint unsigned r, output longint s30,
		output longint c30);
		bit ns, nc, sw, t;
		longint unsigned x, x2, s, c, ps, pc, tmp;
		ns = 0; nc = 0; sw = 0;
		if (r >= PI_Q32) begin
			r -= PI_Q32; ns = 1; nc = 1;
		end
		if (r >= HALF_PI_Q32) begin
			r -= HALF_PI_Q32; sw = 1; t = ns; ns = nc; nc = !t;
		end
		if (r > HALF_PI_Q32) r = HALF_PI_Q32;
		x = (r > QUARTER_PI_Q32) ? HALF_PI_Q32 - r : r;
		x2 = qmul(x, x);
		s = ONE;
		s = ONE - qmul(x2, s) / 72;
		s = ONE - qmul(x2, s) / 42;
		s = ONE - qmul(x2, s) / 20;
		s = ONE - qmul(x2, s) / 6;
		s = qmul(x, s);
		c = ONE;
		c = ONE - qmul(x2, c) / 90;
		c = ONE - qmul(x2, c) / 56;
		c = ONE - qmul(x2, c) / 30;
		c = ONE - qmul(x2, c) / 12;
		c = ONE - qmul(x2, c) / 2;
		if (r > QUARTER_PI_Q32) begin
			ps = c; pc = s;
		end else begin
			ps = s; pc = c;
		end
		if (sw) begin
			tmp = ps; ps = pc; pc = tmp;
		end
		s30 = to_q30(ps, ns);
		c30 = to_q30(pc, nc);
	endtask

	// predicted rotated pair for one accepted rotate transaction
	task automatic predict_rotation();
		longint a, b, s30, c30;
		longint unsigned coord, r;
		a = first_value;
		b = second_value;
		rotates_seen++;
		if (pair_index >= VEC_DIM_DEF / 2) begin
			want_first.insert(want_first.size(), first_value);
			want_second.insert(want_second.size(), second_value);
			return;
		end
		case (AXIS_MAP[pair_index])
			AXIS_H: coord = pos_height;
			AXIS_W: coord = pos_width;
			default: coord = pos_temporal;
		endcase
		r = (coord * longint'(freq_mem[pair_index])) % TWO_PI_Q32;
		angle_sin_cos(r, s30, c30);
		want_first.insert(want_first.size(), round_clip(a * c30 - b * s30));
		want_second.insert(want_second.size(), round_clip(a * s30 + b * c30));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe) begin
				if (want_first.size() == 0) begin
					report_mismatch("unexpected result", first_out, 32'h0);
				end else begin
					if (first_out !== want_first[0][31:0])
						report_mismatch("first_out", first_out, want_first[0][31:0]);
					if (second_out !== want_second[0][31:0])
						report_mismatch("second_out", second_out, want_second[0][31:0]);
					void'(want_first.pop_front());
					void'(want_second.pop_front());
				end
			end
			if (start && !busy) begin
				if (command == CMD_WRITE)
					freq_mem[pair_index] = freq_value;
				else
					predict_rotation();
			end
			pending = want_first.size();
		end
	end
endmodule

### tb/testbench.sv
// testbench top for the rotary position rotate block: stimulus, clock, reset and verdict
module testbench;
	import marpr_pkg::*;

	logic clk, arst_n, start, busy, command, strobe;
	logic [5:0] pair_index;
	logic [31:0] freq_value;
	logic [15:0] pos_temporal, pos_height, pos_width;
	logic signed [31:0] first_value, second_value, first_out, second_out;
	int fail_count, pending, rotates_seen;
	int cycle_count;
	int writes_sent;
	bit written [TABLE_DEPTH];

	multi_axis_rotary_position_rotate u_dut (.*);

	rotate_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// hard limit on run length
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 200000) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("multi_axis_rotary_position_rotate test failed");
				$finish;
			end
		end
	end

	// drive one transaction at the falling edge and hold until it is taken
	task automatic send(input logic cmd, input logic [5:0] idx, input logic [31:0] fq,
		input logic [15:0] pt, input logic [15:0] ph, input logic [15:0] pw,
		input logic [31:0] a, input logic [31:0] b);
		start <= 1; command <= cmd; pair_index <= idx; freq_value <= fq;
		pos_temporal <= pt; pos_height <= ph; pos_width <= pw;
		first_value <= a; second_value <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		if (cmd == CMD_WRITE) begin
			written[idx] = 1;
			writes_sent++;
		end
	endtask

	task automatic idle_burst(input bit allow);
		int n;
		if (allow && $urandom_range(0, 3) == 0) begin
			start <= 0;
			n = $urandom_range(1, 4);
			repeat (n) @(negedge clk);
		end
	endtask

	// rotate on a random index that has a table entry
	task automatic random_rotate();
		logic [5:0] idx;
		do idx = 6'($urandom_range(0, 63)); while (!written[idx]);
		send(CMD_ROTATE, idx, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
			($urandom_range(0, 7) == 0) ? 32'h7fffffff : $urandom,
			($urandom_range(0, 7) == 0) ? 32'h80000000 : $urandom);
	endtask

	initial begin
		logic [31:0] fq;
		start = 0; command = 0; pair_index = 0; freq_value = 0;
		pos_temporal = 0; pos_height = 0; pos_width = 0;
		first_value = 0; second_value = 0;
		writes_sent = 0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: fill the whole table with real frequencies, extremes at the ends
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			fq = (i == 0) ? 32'hffffffff : (i == 63) ? 32'h0 : 32'h1 << (31 - i / 2);
			send(CMD_WRITE, i[5:0], fq, 0, 0, 0, 0, 0);
		end
		// directed rotates: each axis, extreme coordinates, saturation, pairs past the axis limit
		send(CMD_ROTATE, 0, 0, 16'hffff, 0, 0, 32'h7fffffff, 32'h7fffffff);
		send(CMD_ROTATE, 1, 0, 0, 16'hffff, 0, 32'h80000000, 32'h80000000);
		send(CMD_ROTATE, 2, 0, 0, 0, 16'hffff, 32'h00010000, 32'hffff0000);
		send(CMD_ROTATE, 59, 0, 16'h1234, 16'h5678, 16'h9abc, 32'h7fffffff, 32'h80000000);
		send(CMD_ROTATE, 60, 0, 16'hffff, 0, 0, 32'h12345678, 32'h87654321);
		send(CMD_ROTATE, 61, 0, 0, 16'hffff, 16'hffff, 32'h80000000, 32'h7fffffff);
		send(CMD_ROTATE, 63, 0, 16'h8000, 0, 0, 32'h00010000, 32'h00010000);
		send(CMD_ROTATE, 0, 0, 0, 0, 0, 32'h00010000, 32'h0);
		send(CMD_ROTATE, 3, 0, 16'h0001, 16'hffff, 16'hffff, 32'h0, 32'h00010000);

		// let everything drain before the random part
		start <= 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);

		// random mix, mostly rotates with occasional table rewrites
		for (int k = 0; k < 1250; k++) begin
			if ($urandom_range(0, 9) == 0)
				send(CMD_WRITE, 6'($urandom_range(0, 63)), $urandom, 16'($urandom),
					16'($urandom), 16'($urandom), $urandom, $urandom);
			else
				random_rotate();
			if (k == 600) begin
				start <= 0;
				@(negedge clk);
				while (pending != 0) @(negedge clk);
			end
			idle_burst(k < 1000);
		end
		start <= 0;

		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		$display("covered %0d table writes and %0d rotates over all axes and extremes",
			writes_sent, rotates_seen);
		if (fail_count == 0)
			$display("multi_axis_rotary_position_rotate test passed");
		else
			$display("multi_axis_rotary_position_rotate test failed");
		$finish;
	end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/marpr_pkg.sv
rtl/core/marpr_ram.sv
rtl/core/marpr_delay.sv
rtl/core/marpr_mod_cell.sv
rtl/core/marpr_step_cell.sv
rtl/core/multi_axis_rotary_position_rotate.sv
rtl/core/marpr_checker.sv
tb/rotate_checker.sv
tb/testbench.sv
